@@ rtl/gsfr_pkg.sv @@
// Shared types and constants for the gas sensor frame receiver.
// Used by gsfr_parser and gas_sensor_frame_receiver; depends on nothing.
`default_nettype none

package gsfr_pkg;

  localparam logic [7:0]  START_BYTE    = 8'hFF;
  localparam logic [7:0]  TYPE_BYTE     = 8'h86;
  localparam int          FRAME_LEN     = 9;
  localparam int          POS_W         = 4;
  localparam logic [POS_W-1:0] POS_IDLE  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_TYPE  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_HIGH  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LOW   = POS_W'(3);
  localparam logic [POS_W-1:0] POS_CHECK = POS_W'(FRAME_LEN - 1);
  localparam logic [15:0] MAX_PPM_RESET = 16'd5000;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_READ = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_DATA = 2'd1,
    ST_NO_READ = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] ppm_value;
    status_t     read_status;
    logic        data_ready;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/gsfr_parser.sv @@
// Frame parser: running checksum, value capture, latest value and ready flag.
// Depends on gsfr_pkg; one transfer is processed per cycle when step is high.
`default_nettype none

module gsfr_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  gsfr_pkg::action_t      action,
  input  wire logic [7:0]        rx_byte,
  input  wire logic [15:0]       max_ppm,
  output gsfr_pkg::result_t      result
);

  logic [gsfr_pkg::POS_W-1:0] frame_position, frame_position_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  value_high_byte, value_high_byte_next;
  logic [7:0]  value_low_byte, value_low_byte_next;
  logic [15:0] latest_ppm, latest_ppm_next;
  logic        ready_flag, ready_flag_next;
  logic [15:0] frame_value;

  assign frame_value = {value_high_byte, value_low_byte};

  always_comb begin
    frame_position_next  = frame_position;
    running_sum_next     = running_sum;
    value_high_byte_next = value_high_byte;
    value_low_byte_next  = value_low_byte;
    latest_ppm_next      = latest_ppm;
    ready_flag_next      = ready_flag;
    result.ppm_value     = 16'd0;
    result.read_status   = gsfr_pkg::ST_NO_READ;

    if (step) begin
      if (action == gsfr_pkg::ACT_BYTE) begin
        if (frame_position == gsfr_pkg::POS_IDLE) begin
          if (rx_byte == gsfr_pkg::START_BYTE) begin
            frame_position_next = gsfr_pkg::POS_TYPE;
            running_sum_next    = 8'd0;
          end
        end else if (frame_position == gsfr_pkg::POS_TYPE) begin
          if (rx_byte != gsfr_pkg::TYPE_BYTE) begin
            // A repeated start byte is taken as the start of a new frame.
            frame_position_next = (rx_byte == gsfr_pkg::START_BYTE) ?
                                  gsfr_pkg::POS_TYPE : gsfr_pkg::POS_IDLE;
            running_sum_next    = 8'd0;
          end else begin
            frame_position_next = gsfr_pkg::POS_HIGH;
            running_sum_next    = rx_byte;
          end
        end else if (frame_position < gsfr_pkg::POS_CHECK) begin
          if (frame_position == gsfr_pkg::POS_HIGH) begin
            value_high_byte_next = rx_byte;
          end
          if (frame_position == gsfr_pkg::POS_LOW) begin
            value_low_byte_next = rx_byte;
          end
          running_sum_next    = running_sum + rx_byte;
          frame_position_next = frame_position + gsfr_pkg::POS_W'(1);
        end else begin
          if (((8'd0 - running_sum) == rx_byte) && (frame_value <= max_ppm)) begin
            latest_ppm_next = frame_value;
            ready_flag_next = 1'b1;
          end
          frame_position_next = gsfr_pkg::POS_IDLE;
          running_sum_next    = 8'd0;
        end
      end else if (ready_flag) begin
        result.ppm_value   = latest_ppm;
        result.read_status = gsfr_pkg::ST_OK;
        ready_flag_next    = 1'b0;
      end else begin
        result.read_status = gsfr_pkg::ST_NO_DATA;
      end
    end

    result.data_ready = ready_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= gsfr_pkg::POS_IDLE;
      running_sum    <= 8'd0;
      latest_ppm     <= 16'd0;
      ready_flag     <= 1'b0;
    end else begin
      frame_position <= frame_position_next;
      running_sum    <= running_sum_next;
      latest_ppm     <= latest_ppm_next;
      ready_flag     <= ready_flag_next;
    end
  end

  // Captured value bytes are always written by a frame before it reads them.
  always_ff @(posedge clk) begin
    value_high_byte <= value_high_byte_next;
    value_low_byte  <= value_low_byte_next;
  end

endmodule

`default_nettype wire

@@ rtl/gas_sensor_frame_receiver.sv @@
// Gas sensor frame receiver top level: stream ports, input and result registers.
// An accepted transfer is held in the input register, then its result in the result register.
// Throughput: one transfer per cycle unless the output stalls; a step updates all parser state.
// Reset (rst, synchronous): empties both registers, clears frame state, latest value
// and ready flag, and loads max_ppm with 5000. Depends on gsfr_pkg and gsfr_parser.
`default_nettype none

module gas_sensor_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]  s_tuser,   // [0] action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [15:0] ppm_value, [16] data_ready, rest zero
  output logic [1:0]       m_tuser,   // [1:0] read_status
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic                in_valid;
  gsfr_pkg::action_t   in_action;
  logic [7:0]          in_byte;
  logic                out_valid;
  gsfr_pkg::result_t   out_result;
  gsfr_pkg::result_t   step_result;
  logic [15:0]         max_ppm;
  logic                advance;
  logic                step;
  logic                reg_sel;

  assign advance  = !out_valid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= gsfr_pkg::action_t'(s_tuser[0]);
      in_byte   <= s_tdata;
    end
    if (step) begin
      out_result <= step_result;
    end
  end

  gsfr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .action  (in_action),
    .rx_byte (in_byte),
    .max_ppm (max_ppm),
    .result  (step_result)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_result.data_ready, out_result.ppm_value};
  assign m_tuser  = out_result.read_status;

  // Configuration port: one register, decoded at byte addresses 0 to 3.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'b0);
  assign prdata  = reg_sel ? {16'd0, max_ppm} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_ppm <= gsfr_pkg::MAX_PPM_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      max_ppm <= pwdata[15:0];
    end
  end

  // A successful read always leaves the ready flag cleared.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == gsfr_pkg::ST_OK) |-> !m_tdata[16])
    else $error("ready flag still set after a successful read");

  // Anything but a successful read reports a zero value.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == gsfr_pkg::ST_NO_DATA || m_tuser == gsfr_pkg::ST_NO_READ))
    |-> (m_tdata[15:0] == 16'd0))
    else $error("nonzero value without a successful read");

  // A failed read means no unread value was held.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == gsfr_pkg::ST_NO_DATA) |-> !m_tdata[16])
    else $error("no-data status while a value is ready");

endmodule

`default_nettype wire

@@ verif/tb_gas_sensor_frame_receiver.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for gas_sensor_frame_receiver: streams sensor bytes and
// read requests, predicts each reading in step with the frame parser and compares.
// Depends on gsfr_pkg and the gas_sensor_frame_receiver RTL.

module tb_gas_sensor_frame_receiver;

  localparam logic [2:0] REG_MAX_PPM = 3'd0;

  typedef enum int {
    FRM_GOOD,
    FRM_BAD_SUM,
    FRM_CUT,
    FRM_RESTART
  } frame_kind_t;

  typedef struct packed {
    gsfr_pkg::action_t act;
    logic [7:0]        rx;
  } rx_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
  logic [0:0]  s_tuser = 1'b0;    // [0] action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;           // [15:0] ppm_value, [16] data_ready
  logic [1:0]  m_tuser;           // [1:0] read_status
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  gas_sensor_frame_receiver dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  rx_item_t           pending_rx[$];
  gsfr_pkg::result_t  awaited_readings[$];
  rx_item_t           next_rx;
  int          queued_items = 0;
  int          errors = 0;
  int          values_latched = 0;
  int          reads_served = 0;
  int          src_gap = 0;
  int          sink_gap = 0;
  logic        in_fire = 1'b0;
  logic        calm = 1'b0;

  // Parser state as the predictor sees it.
  logic [3:0]  frm_pos;
  logic [7:0]  frm_sum;
  logic [7:0]  frm_high;
  logic [7:0]  frm_low;
  logic [15:0] held_ppm;
  logic        unread;
  logic [15:0] ppm_limit;

  function automatic gsfr_pkg::result_t parse_and_read(input gsfr_pkg::action_t act,
                                                       input logic [7:0] rx);
    gsfr_pkg::result_t r;
    r.ppm_value   = 16'd0;
    r.read_status = gsfr_pkg::ST_NO_READ;
    if (act == gsfr_pkg::ACT_BYTE) begin
      if (frm_pos == gsfr_pkg::POS_IDLE) begin
        if (rx == gsfr_pkg::START_BYTE) begin
          frm_pos = gsfr_pkg::POS_TYPE;
          frm_sum = 8'd0;
        end
      end else if (frm_pos == gsfr_pkg::POS_TYPE) begin
        if (rx == gsfr_pkg::TYPE_BYTE) begin
          frm_sum = rx;
          frm_pos = gsfr_pkg::POS_HIGH;
        end else begin
          // A second start byte counts as a fresh frame start.
          frm_pos = (rx == gsfr_pkg::START_BYTE) ? gsfr_pkg::POS_TYPE : gsfr_pkg::POS_IDLE;
          frm_sum = 8'd0;
        end
      end else if (frm_pos != gsfr_pkg::POS_CHECK) begin
        if (frm_pos == gsfr_pkg::POS_HIGH) frm_high = rx;
        if (frm_pos == gsfr_pkg::POS_LOW) frm_low = rx;
        frm_sum = frm_sum + rx;
        frm_pos = frm_pos + 4'd1;
      end else begin
        if (8'(8'd0 - frm_sum) == rx && {frm_high, frm_low} <= ppm_limit) begin
          held_ppm = {frm_high, frm_low};
          unread   = 1'b1;
          values_latched++;
        end
        frm_pos = gsfr_pkg::POS_IDLE;
        frm_sum = 8'd0;
      end
    end else if (unread) begin
      r.ppm_value   = held_ppm;
      r.read_status = gsfr_pkg::ST_OK;
      unread        = 1'b0;
      reads_served++;
    end else begin
      r.read_status = gsfr_pkg::ST_NO_DATA;
    end
    r.data_ready = unread;
    return r;
  endfunction

  // Prediction, register shadowing and result checking, all on the rising edge.
  always @(posedge clk) begin
    gsfr_pkg::result_t got_exp;
    if (rst) begin
      frm_pos   = gsfr_pkg::POS_IDLE;
      frm_sum   = 8'd0;
      frm_high  = 8'd0;
      frm_low   = 8'd0;
      held_ppm  = 16'd0;
      unread    = 1'b0;
      ppm_limit = gsfr_pkg::MAX_PPM_RESET;
      awaited_readings.delete();
      in_fire <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_MAX_PPM)
        ppm_limit = pwdata[15:0];
      if (m_tvalid && m_tready) begin
        if (awaited_readings.size() == 0) begin
          $error("result transfer with nothing expected: tdata=%h tuser=%h",
                 m_tdata, m_tuser);
          errors++;
        end else begin
          got_exp = awaited_readings.pop_front();
          if (m_tdata[15:0] !== got_exp.ppm_value) begin
            $error("ppm_value expected %0d actual %0d", got_exp.ppm_value, m_tdata[15:0]);
            errors++;
          end
          if (m_tuser !== got_exp.read_status) begin
            $error("read_status expected %0d actual %0d", got_exp.read_status, m_tuser);
            errors++;
          end
          if (m_tdata[16] !== got_exp.data_ready) begin
            $error("data_ready expected %0d actual %0d", got_exp.data_ready, m_tdata[16]);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready)
        awaited_readings.push_back(parse_and_read(gsfr_pkg::action_t'(s_tuser[0]),
                                                  s_tdata));
      in_fire <= s_tvalid && s_tready;
    end
  end

  // Source side: moves to the next byte or read once the current transfer is done.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap  <= 0;
    end else if (!s_tvalid || in_fire) begin
      if (src_gap != 0) begin
        s_tvalid <= 1'b0;
        src_gap  <= src_gap - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        s_tvalid <= 1'b0;
        src_gap  <= $urandom_range(0, 5);
      end else if (pending_rx.size() != 0) begin
        next_rx   = pending_rx.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= next_rx.rx;
        s_tuser  <= next_rx.act;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Sink side: random back-pressure bursts.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap <= 0;
    end else if (sink_gap != 0) begin
      m_tready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      sink_gap <= $urandom_range(0, 5);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic queue_item(input gsfr_pkg::action_t act, input logic [7:0] rx);
    rx_item_t it;
    it.act = act;
    it.rx  = rx;
    pending_rx.push_back(it);
    queued_items++;
  endtask

  // Bytes 1 to 7 of a frame follow the start byte; the checksum closes it.
  task automatic queue_frame(input logic [15:0] ppm, input frame_kind_t kind);
    logic [7:0] body [7];
    logic [7:0] sum;
    int         cut;
    body[0] = gsfr_pkg::TYPE_BYTE;
    body[1] = ppm[15:8];
    body[2] = ppm[7:0];
    for (int i = 3; i < 7; i++) body[i] = 8'($urandom);
    sum = 8'd0;
    for (int i = 0; i < 7; i++) sum = sum + body[i];
    if (kind == FRM_RESTART) queue_item(gsfr_pkg::ACT_BYTE, gsfr_pkg::START_BYTE);
    queue_item(gsfr_pkg::ACT_BYTE, gsfr_pkg::START_BYTE);
    cut = (kind == FRM_CUT) ? $urandom_range(0, 6) : 7;
    for (int i = 0; i < cut; i++) queue_item(gsfr_pkg::ACT_BYTE, body[i]);
    if (kind == FRM_GOOD || kind == FRM_RESTART)
      queue_item(gsfr_pkg::ACT_BYTE, 8'(8'd0 - sum));
    else if (kind == FRM_BAD_SUM)
      queue_item(gsfr_pkg::ACT_BYTE, 8'(8'd0 - sum + 8'($urandom_range(1, 255))));
  endtask

  function automatic logic [15:0] pick_ppm(input logic [15:0] lim);
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return lim;
      2: return lim + 16'd1;
      3: return 16'hFFFF;
      4: return 16'($urandom_range(0, lim));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_random_group(input logic [15:0] lim);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) queue_frame(pick_ppm(lim), FRM_GOOD);
    else if (pick < 60) queue_frame(pick_ppm(lim), FRM_BAD_SUM);
    else if (pick < 68) queue_frame(pick_ppm(lim), FRM_CUT);
    else if (pick < 76) queue_frame(pick_ppm(lim), FRM_RESTART);
    else if (pick < 90) queue_item(gsfr_pkg::ACT_READ, 8'($urandom));
    else queue_item(gsfr_pkg::ACT_BYTE, 8'($urandom));
    if (pick < 76 && $urandom_range(0, 1) == 1) queue_item(gsfr_pkg::ACT_READ, 8'($urandom));
  endtask

  // Waits until every queued item is taken and every reading is back.
  task automatic drain();
    while (pending_rx.size() != 0 || s_tvalid) @(posedge clk);
    while (awaited_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_ppm(input logic [15:0] lim);
    logic [31:0] rd;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_MAX_PPM;
    pwdata  <= {16'd0, lim};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[15:0] !== lim) begin
      $error("max_ppm readback expected %0d actual %0d", lim, rd[15:0]);
      errors++;
    end
  endtask

  task automatic run_phase(input logic [15:0] lim, input int count);
    int start;
    write_max_ppm(lim);
    start = queued_items;
    while (queued_items - start < count) queue_random_group(lim);
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset limit of 5000 ppm.
    queue_item(gsfr_pkg::ACT_READ, 8'hFF);            // read with nothing held
    queue_item(gsfr_pkg::ACT_BYTE, 8'h00);            // ignored while hunting for a start
    queue_item(gsfr_pkg::ACT_BYTE, gsfr_pkg::START_BYTE);
    queue_item(gsfr_pkg::ACT_BYTE, 8'h00);            // bad second byte drops back to hunting
    queue_frame(16'd5000, FRM_RESTART);     // doubled start, value right at the limit
    queue_item(gsfr_pkg::ACT_READ, 8'h00);
    queue_item(gsfr_pkg::ACT_READ, 8'h5A);            // second read finds no new data
    queue_frame(16'd5001, FRM_GOOD);        // just above the limit, dropped
    queue_item(gsfr_pkg::ACT_READ, 8'hA5);
    drain();

    run_phase(16'hFFFF, 250);
    run_phase(16'd0, 150);
    run_phase(16'($urandom), 300);
    calm = 1'b1;
    run_phase(gsfr_pkg::MAX_PPM_RESET, 250);

    $display("Sent %0d bytes and reads over five phases of max_ppm (5000, 65535, 0, %s",
             queued_items, "random, 5000).");
    $display("Frames latched: %0d, reads served with data: %0d.",
             values_latched, reads_served);
    if (errors == 0) begin
      $display("tb_gas_sensor_frame_receiver: PASS");
    end else begin
      $display("tb_gas_sensor_frame_receiver: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_gas_sensor_frame_receiver: FAIL");
    $finish;
  end

endmodule

@@ gas_sensor_frame_receiver.f @@
rtl/gsfr_pkg.sv
rtl/gsfr_parser.sv
rtl/gas_sensor_frame_receiver.sv
verif/tb_gas_sensor_frame_receiver.sv
